// ----- rtl/core/rfid_gated_flap_lock_controller_macros.svh -----
// Assertion macros shared by the flap lock controller RTL.
// No dependencies; include by bare file name.
`ifndef RFID_GATED_FLAP_LOCK_CONTROLLER_MACROS_SVH
`define RFID_GATED_FLAP_LOCK_CONTROLLER_MACROS_SVH

// same-cycle implication, async active-low reset disables the check
`define RFGFL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rfgfl assertion failed");

// next-cycle implication
`define RFGFL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rfgfl assertion failed");

`endif

// ----- rtl/core/rfgfl_pkg.sv -----
// Types, constants and helpers for the flap lock controller.
// No dependencies; used by the top level, rfgfl_front and rfgfl_back in rtl/core.
package rfgfl_pkg;

  localparam int unsigned TAG_SLOTS   = 16;
  localparam int unsigned FRAME_BYTES = 29;
  localparam int unsigned ID_DIGITS   = 10;
  localparam int unsigned TAG_W       = 40;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned DIG_W       = 4;
  localparam int unsigned TMR_W       = 16;
  localparam logic [7:0]  HDR_BYTE    = 8'h02;

  localparam logic [TMR_W-1:0] MOTION_TO_RST = 16'd10000;
  localparam logic [TMR_W-1:0] UNLOCK_RST    = 16'd5000;
  localparam logic [TMR_W-1:0] RDR_RST_RST   = 16'd2000;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_BYTE  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_READING  = 2'd1,
    MODE_UNLOCKED = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_SKIP    = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PERMIT  = 2'd1,
    EV_DENIED  = 2'd2,
    EV_UNKNOWN = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    REG_FLAP_DIR   = 3'd0,
    REG_ALLOW_IN   = 3'd1,
    REG_ALLOW_OUT  = 3'd2,
    REG_MOTION_TO  = 3'd3,
    REG_UNLOCK     = 3'd4,
    REG_RDR_RST    = 3'd5
  } reg_e;

  typedef struct packed {
    op_e               op;
    logic              motion;
    logic [7:0]        rx_byte;
    logic [SLOT_W-1:0] slot_index;
    logic [TAG_W-1:0]  slot_tag;
    logic              slot_valid;
    logic              slot_allow_in;
    logic              slot_allow_out;
  } item_t;

  typedef struct packed {
    logic             flap_direction;
    logic             allow_in_global;
    logic             allow_out_global;
    logic [TMR_W-1:0] motion_timeout_ms;
    logic [TMR_W-1:0] unlock_hold_ms;
    logic [TMR_W-1:0] reader_reset_ms;
  } cfg_t;

  // {is_hex, nibble}
  function automatic logic [DIG_W:0] hex_digit(input logic [7:0] c);
    logic [DIG_W:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [TMR_W-1:0] sat_inc(input logic [TMR_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

// ----- rtl/core/rfgfl_if.sv -----
// Channel interfaces for the flap lock controller.
// No dependencies.
interface rfgfl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic        motion;
  logic [7:0]  rx_byte;
  logic [3:0]  slot_index;
  logic [39:0] slot_tag;
  logic        slot_valid;
  logic        slot_allow_in;
  logic        slot_allow_out;

  modport source (output valid, operation, motion, rx_byte, slot_index, slot_tag,
                  slot_valid, slot_allow_in, slot_allow_out, input ready);
  modport sink   (input valid, operation, motion, rx_byte, slot_index, slot_tag,
                  slot_valid, slot_allow_in, slot_allow_out, output ready);
endinterface

interface rfgfl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        servo_enable;
  logic        lock_engaged;
  logic        reader_power;
  logic        reader_reset_pulse;
  logic [1:0]  tag_event;
  logic [39:0] tag_value;

  modport source (output valid, mode, servo_enable, lock_engaged, reader_power,
                  reader_reset_pulse, tag_event, tag_value, input ready);
  modport sink   (input valid, mode, servo_enable, lock_engaged, reader_power,
                  reader_reset_pulse, tag_event, tag_value, output ready);
endinterface

// ----- rtl/core/rfid_gated_flap_lock_controller.sv -----
// Top level of the RFID gated flap lock controller: APB register file,
// front queue and back end. Depends on rfgfl_pkg, rfgfl_if, rfgfl_front, rfgfl_back.
//
//   channel  dir  handshake       payload
//   in_ch    in   valid/ready     operation, motion, rx_byte, slot_* fields
//   out_ch   out  valid/ready     mode, servo/lock/power, pulse, tag_event/value
//   apb      in   psel/penable    paddr[4:0], pwdata, prdata; pready tied high
//
// One item per cycle sustained while the output is not stalled; an item's result appears in the
// cycle after it leaves the two-entry front queue, passing through the queue and the output register.
// The back end's combinational tag decode and 16-way compare set that rate.
// rst_ni clears control state and the tag table valid bits at once.
// A stalled output holds its register; the front queue keeps accepting until full.
module rfid_gated_flap_lock_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfgfl_in_if.sink    in_ch,
  rfgfl_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rfgfl_pkg::*;

  cfg_t  cfg_q;
  item_t item;
  logic  item_valid, item_ready;
  logic  wr_en;
  reg_e  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flap_direction    <= 1'b0;
      cfg_q.allow_in_global   <= 1'b1;
      cfg_q.allow_out_global  <= 1'b1;
      cfg_q.motion_timeout_ms <= MOTION_TO_RST;
      cfg_q.unlock_hold_ms    <= UNLOCK_RST;
      cfg_q.reader_reset_ms   <= RDR_RST_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_FLAP_DIR:  cfg_q.flap_direction    <= pwdata[0];
        REG_ALLOW_IN:  cfg_q.allow_in_global   <= pwdata[0];
        REG_ALLOW_OUT: cfg_q.allow_out_global  <= pwdata[0];
        REG_MOTION_TO: cfg_q.motion_timeout_ms <= pwdata[TMR_W-1:0];
        REG_UNLOCK:    cfg_q.unlock_hold_ms    <= pwdata[TMR_W-1:0];
        REG_RDR_RST:   cfg_q.reader_reset_ms   <= pwdata[TMR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FLAP_DIR:  prdata = {31'd0, cfg_q.flap_direction};
      REG_ALLOW_IN:  prdata = {31'd0, cfg_q.allow_in_global};
      REG_ALLOW_OUT: prdata = {31'd0, cfg_q.allow_out_global};
      REG_MOTION_TO: prdata = {16'd0, cfg_q.motion_timeout_ms};
      REG_UNLOCK:    prdata = {16'd0, cfg_q.unlock_hold_ms};
      REG_RDR_RST:   prdata = {16'd0, cfg_q.reader_reset_ms};
      default:       prdata = '0;
    endcase
  end

  rfgfl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  rfgfl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .cfg_i        (cfg_q),
    .out_ch       (out_ch)
  );

endmodule

// ----- rtl/core/rfgfl_front.sv -----
// Front end: accepts input transfers, classifies the operation, and buffers
// items in a two-entry queue. Depends on rfgfl_pkg and rfgfl_in_if.
`include "rfid_gated_flap_lock_controller_macros.svh"
module rfgfl_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  rfgfl_in_if.sink         in_ch,
  output rfgfl_pkg::item_t item_o,
  output logic             item_valid_o,
  input  logic             item_ready_i
);
  import rfgfl_pkg::*;

  localparam int unsigned QDEPTH = 2;

  item_t      q_mem [QDEPTH];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  item_t      in_item;

  always_comb begin
    in_item.op             = op_e'(in_ch.operation);
    in_item.motion         = in_ch.motion;
    in_item.rx_byte        = in_ch.rx_byte;
    in_item.slot_index     = in_ch.slot_index;
    in_item.slot_tag       = in_ch.slot_tag;
    in_item.slot_valid     = in_ch.slot_valid;
    in_item.slot_allow_in  = in_ch.slot_allow_in;
    in_item.slot_allow_out = in_ch.slot_allow_out;
  end

  assign in_ch.ready  = (cnt_q != 2'(QDEPTH));
  assign push         = in_ch.valid && in_ch.ready;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= in_item;
    end
  end

  `RFGFL_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= 2'(QDEPTH))
  `RFGFL_ASSERT_IMP(a_ptr_sync, clk_i, rst_ni, cnt_q == 2'd1, wr_ptr_q != rd_ptr_q)

endmodule

// ----- rtl/core/rfgfl_back.sv -----
// Back end: mode control, timers, frame parser, tag table and output register.
// Depends on rfgfl_pkg and rfgfl_out_if.
`include "rfid_gated_flap_lock_controller_macros.svh"
module rfgfl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rfgfl_pkg::item_t item_i,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  rfgfl_pkg::cfg_t  cfg_i,
  rfgfl_out_if.source      out_ch
);
  import rfgfl_pkg::*;

  localparam int unsigned DIDX_W = $clog2(ID_DIGITS);

  // control state
  mode_e            mode_q, mode_d;
  logic             servo_q, servo_d, lock_q, lock_d, power_q, power_d;
  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [TMR_W-1:0] smot_q, smot_d, sfrm_q, sfrm_d, stag_q, stag_d;
  logic             slot_vld_q [TAG_SLOTS];

  // payload storage
  logic [DIG_W-1:0] dig_q [ID_DIGITS];
  logic             hex_q [ID_DIGITS];
  logic [TAG_W-1:0] slot_tag_q [TAG_SLOTS];
  logic             slot_in_q  [TAG_SLOTS];
  logic             slot_out_q [TAG_SLOTS];

  // output register
  logic             ovld_q;
  mode_e            omode_q;
  logic             oservo_q, olock_q, opower_q, opulse_q;
  event_e           oev_q;
  logic [TAG_W-1:0] otag_q;

  logic             fire, pulse, dig_we;
  event_e           ev, lookup_ev;
  logic [TAG_W-1:0] id, tagv;
  logic             ok, hit;
  logic [DIG_W:0]   hd;

  assign item_ready_o = !ovld_q || out_ch.ready;
  assign fire         = item_valid_i && item_ready_o;
  assign hd           = hex_digit(item_i.rx_byte);

  // tag from stored digits, most significant first, stop at first non-hex
  always_comb begin
    id = '0;
    ok = 1'b1;
    for (int k = 0; k < ID_DIGITS; k++) begin
      if (ok && hex_q[ID_DIGITS-1-k]) begin
        id = {id[TAG_W-DIG_W-1:0], dig_q[ID_DIGITS-1-k]};
      end else begin
        ok = 1'b0;
      end
    end
  end

  // lowest valid matching slot wins
  always_comb begin
    hit       = 1'b0;
    lookup_ev = EV_UNKNOWN;
    for (int i = 0; i < TAG_SLOTS; i++) begin
      if (!hit && slot_vld_q[i] && slot_tag_q[i] == id) begin
        hit = 1'b1;
        if (cfg_i.flap_direction ? (slot_out_q[i] && cfg_i.allow_out_global)
                                 : (slot_in_q[i] && cfg_i.allow_in_global)) begin
          lookup_ev = EV_PERMIT;
        end else begin
          lookup_ev = EV_DENIED;
        end
      end
    end
  end

  always_comb begin
    mode_d  = mode_q;
    servo_d = servo_q;
    lock_d  = lock_q;
    power_d = power_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    smot_d  = smot_q;
    sfrm_d  = sfrm_q;
    stag_d  = stag_q;
    pulse   = 1'b0;
    ev      = EV_NONE;
    tagv    = '0;
    dig_we  = 1'b0;
    unique case (item_i.op)
      OP_TICK: begin
        if (mode_q == MODE_IDLE) begin
          if (item_i.motion) begin
            servo_d = 1'b1;
            power_d = 1'b1;
            smot_d  = '0;
            stag_d  = '0;
            sfrm_d  = '0;
            phase_d = PH_HUNT;
            cnt_d   = '0;
            pulse   = 1'b1;
            mode_d  = MODE_READING;
          end
        end else begin
          smot_d = item_i.motion ? '0 : sat_inc(smot_q);
          sfrm_d = sat_inc(sfrm_q);
          stag_d = sat_inc(stag_q);
          if (mode_q == MODE_READING && smot_d >= cfg_i.motion_timeout_ms) begin
            servo_d = 1'b0;
            power_d = 1'b0;
            smot_d  = '0;
            sfrm_d  = '0;
            stag_d  = '0;
            phase_d = PH_HUNT;
            cnt_d   = '0;
            mode_d  = MODE_IDLE;
          end else begin
            if (mode_q == MODE_UNLOCKED && stag_d >= cfg_i.unlock_hold_ms) begin
              lock_d  = 1'b1;
              sfrm_d  = '0;
              phase_d = PH_HUNT;
              cnt_d   = '0;
              pulse   = 1'b1;
              mode_d  = MODE_READING;
            end
            if (sfrm_d >= cfg_i.reader_reset_ms) begin
              sfrm_d  = '0;
              phase_d = PH_HUNT;
              cnt_d   = '0;
              pulse   = 1'b1;
            end
          end
        end
      end
      OP_BYTE: begin
        if (mode_q != MODE_IDLE) begin
          unique case (phase_q)
            PH_HUNT: begin
              if (item_i.rx_byte == HDR_BYTE) begin
                phase_d = PH_COLLECT;
                cnt_d   = '0;
              end
            end
            PH_COLLECT: begin
              dig_we = (cnt_q < CNT_W'(ID_DIGITS));
              cnt_d  = cnt_q + 1'b1;
              if (cnt_d >= CNT_W'(FRAME_BYTES)) begin
                phase_d = PH_SKIP;
              end
            end
            default: begin
              phase_d = PH_HUNT;
              cnt_d   = '0;
              stag_d  = '0;
              sfrm_d  = '0;
              if (id != '0) begin
                ev   = lookup_ev;
                tagv = id;
                if (mode_q == MODE_READING && lookup_ev == EV_PERMIT) begin
                  pulse   = 1'b1;
                  lock_d  = 1'b0;
                  power_d = 1'b1;
                  mode_d  = MODE_UNLOCKED;
                end else if (mode_q == MODE_UNLOCKED && lookup_ev != EV_PERMIT) begin
                  pulse  = 1'b1;
                  lock_d = 1'b1;
                  mode_d = MODE_READING;
                end
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      servo_q <= 1'b0;
      lock_q  <= 1'b1;
      power_q <= 1'b0;
      phase_q <= PH_HUNT;
      cnt_q   <= '0;
      smot_q  <= '0;
      sfrm_q  <= '0;
      stag_q  <= '0;
      ovld_q  <= 1'b0;
      for (int i = 0; i < TAG_SLOTS; i++) begin
        slot_vld_q[i] <= 1'b0;
      end
    end else begin
      if (fire) begin
        mode_q  <= mode_d;
        servo_q <= servo_d;
        lock_q  <= lock_d;
        power_q <= power_d;
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        smot_q  <= smot_d;
        sfrm_q  <= sfrm_d;
        stag_q  <= stag_d;
        if (item_i.op == OP_WRITE) begin
          slot_vld_q[item_i.slot_index] <= item_i.slot_valid;
        end
      end
      if (fire) begin
        ovld_q <= 1'b1;
      end else if (out_ch.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      omode_q  <= mode_d;
      oservo_q <= servo_d;
      olock_q  <= lock_d;
      opower_q <= power_d;
      opulse_q <= pulse;
      oev_q    <= ev;
      otag_q   <= tagv;
      if (dig_we) begin
        dig_q[cnt_q[DIDX_W-1:0]] <= hd[DIG_W-1:0];
        hex_q[cnt_q[DIDX_W-1:0]] <= hd[DIG_W];
      end
      if (item_i.op == OP_WRITE) begin
        slot_tag_q[item_i.slot_index] <= item_i.slot_tag;
        slot_in_q[item_i.slot_index]  <= item_i.slot_allow_in;
        slot_out_q[item_i.slot_index] <= item_i.slot_allow_out;
      end
    end
  end

  assign out_ch.valid              = ovld_q;
  assign out_ch.mode               = omode_q;
  assign out_ch.servo_enable       = oservo_q;
  assign out_ch.lock_engaged       = olock_q;
  assign out_ch.reader_power       = opower_q;
  assign out_ch.reader_reset_pulse = opulse_q;
  assign out_ch.tag_event          = oev_q;
  assign out_ch.tag_value          = otag_q;

  `RFGFL_ASSERT_IMP(a_unlock_lock, clk_i, rst_ni, 1'b1, (mode_q == MODE_UNLOCKED) == !lock_q)
  `RFGFL_ASSERT_IMP(a_idle_off, clk_i, rst_ni, mode_q == MODE_IDLE, !servo_q && !power_q)
  `RFGFL_ASSERT_NXT(a_fire_valid, clk_i, rst_ni, fire, ovld_q)

endmodule
